// File: hdl/stx_rx_pkg.sv
// ----------------------------------------------------------------------------
// stx_rx_pkg
// Shared types and constants of the STX length/XOR frame receiver.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package stx_rx_pkg;

	localparam int BYTE_W = 8;
	localparam int IDX_W = 6;
	localparam int LEN_W = 16;

	localparam logic [BYTE_W-1:0] START_BYTE = 8'h02;
	localparam logic [BYTE_W-1:0] ZERO_BYTE = 8'h00;
	localparam int HEADER_BYTES = 4;
	localparam int LEN_LO_POS = 2;
	localparam int LEN_HI_POS = 3;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_LOAD
	} stx_state_t;

endpackage

// File: hdl/stx_rx_if.sv
// ----------------------------------------------------------------------------
// stx_rx_if / stx_frame_if
// Valid/ready channels for received bytes and for validated frame bytes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface stx_rx_if;
	logic                           valid;
	logic                           ready;
	logic [stx_rx_pkg::BYTE_W-1:0] rx_byte;
	logic                           burst_start;

	modport source (output valid, output rx_byte, output burst_start, input ready);
	modport sink (input valid, input rx_byte, input burst_start, output ready);
endinterface

interface stx_frame_if;
	logic                           valid;
	logic                           ready;
	logic [stx_rx_pkg::BYTE_W-1:0] frame_byte;
	logic [stx_rx_pkg::IDX_W-1:0]  byte_index;
	logic                           last_byte;

	modport source (output valid, output frame_byte, output byte_index, output last_byte,
		input ready);
	modport sink (input valid, input frame_byte, input byte_index, input last_byte,
		output ready);
endinterface

// File: hdl/stx_rx_store.sv
// ----------------------------------------------------------------------------
// stx_rx_store
// Frame store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stx_rx_store #(
	parameter int DEPTH = 64,
	parameter int AW = 6
) (
	input  logic                           clk,
	input  logic                           we,
	input  logic [AW-1:0]                  waddr,
	input  logic [stx_rx_pkg::BYTE_W-1:0] wdata,
	input  logic                           re,
	input  logic [AW-1:0]                  raddr,
	output logic [stx_rx_pkg::BYTE_W-1:0] rdata
);
	import stx_rx_pkg::*;

	logic [BYTE_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: hdl/stx_length_xor_frame_receiver.sv
// ----------------------------------------------------------------------------
// stx_length_xor_frame_receiver
// Each received byte is taken while the block is idle.
// A frame with a good checksum is then read out of the store through the
// single read port, each frame byte in a read state and then a load state that
// waits while the output stalls; no byte is taken until the last frame byte is
// loaded into the output. Reset clears the hunting state and sets
// accept_headless; the store is not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stx_length_xor_frame_receiver #(
	parameter int FRAME_BYTES = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	stx_rx_if.sink        rx_in,
	stx_frame_if.source   fr_out,
	input  logic          cfg_we,
	input  logic          cfg_wdata
);
	import stx_rx_pkg::*;

	localparam int AW = $clog2(FRAME_BYTES);
	localparam int CMP_W = LEN_W + 1;

	stx_state_t state_q, state_d;

	logic              accept_headless_q;
	logic              in_frame_q, in_frame_d;
	logic              hl_allowed_q, hl_allowed_d;
	logic [AW-1:0]     cnt_q, cnt_d;
	logic [BYTE_W-1:0] xor_q, xor_d;
	logic [LEN_W-1:0]  len_q, len_d;
	logic [AW-1:0]     k_q;
	logic [AW-1:0]     last_q;

	logic              take;
	logic              in_fr;
	logic              hl_eff;
	logic              wr_en;
	logic [AW-1:0]     wr_addr;
	logic              emit_go;
	logic              rd_en;
	logic              load;
	logic [LEN_W-1:0]  len_new;
	logic [BYTE_W-1:0] rd_data;

	logic              ovld_q;
	logic [BYTE_W-1:0] obyte_q;
	logic [IDX_W-1:0]  oidx_q;
	logic              olast_q;

	stx_rx_store #(
		.DEPTH (FRAME_BYTES),
		.AW    (AW)
	) u_store (
		.clk   (clk),
		.we    (take & wr_en),
		.waddr (wr_addr),
		.wdata (rx_in.rx_byte),
		.re    (rd_en),
		.raddr (k_q),
		.rdata (rd_data)
	);

	// byte handling
	always_comb begin
		in_fr        = in_frame_q & ~rx_in.burst_start;
		hl_eff       = hl_allowed_q | rx_in.burst_start;
		in_frame_d   = in_fr;
		hl_allowed_d = hl_eff;
		cnt_d        = in_fr ? cnt_q : '0;
		xor_d        = in_fr ? xor_q : '0;
		len_d        = in_fr ? len_q : '0;
		wr_en        = 1'b0;
		wr_addr      = cnt_q;
		emit_go      = 1'b0;
		len_new      = {rx_in.rx_byte, len_q[BYTE_W-1:0]};
		if (!in_fr) begin
			if (rx_in.rx_byte == START_BYTE) begin
				in_frame_d   = 1'b1;
				hl_allowed_d = 1'b0;
				cnt_d        = AW'(1);
				xor_d        = START_BYTE;
			end else if (rx_in.rx_byte != ZERO_BYTE && hl_eff && accept_headless_q) begin
				in_frame_d   = 1'b1;
				hl_allowed_d = 1'b0;
				cnt_d        = AW'(2);
				xor_d        = START_BYTE ^ rx_in.rx_byte;
				wr_en        = 1'b1;
				wr_addr      = AW'(1);
			end
		end else if (cnt_q < AW'(HEADER_BYTES)) begin
			wr_en = 1'b1;
			cnt_d = cnt_q + AW'(1);
			xor_d = xor_q ^ rx_in.rx_byte;
			if (cnt_q == AW'(LEN_LO_POS)) begin
				len_d = {{(LEN_W-BYTE_W){1'b0}}, rx_in.rx_byte};
			end
			if (cnt_q == AW'(LEN_HI_POS)) begin
				len_d = len_new;
				if ({1'b0, len_new} + CMP_W'(HEADER_BYTES + 1) > CMP_W'(FRAME_BYTES)) begin
					in_frame_d = 1'b0;
					cnt_d      = '0;
					xor_d      = '0;
					len_d      = '0;
				end
			end
		end else if (CMP_W'(cnt_q) < {1'b0, len_q} + CMP_W'(HEADER_BYTES)) begin
			wr_en = 1'b1;
			cnt_d = cnt_q + AW'(1);
			xor_d = xor_q ^ rx_in.rx_byte;
		end else begin
			// checksum byte
			in_frame_d = 1'b0;
			cnt_d      = '0;
			xor_d      = '0;
			len_d      = '0;
			if (rx_in.rx_byte == xor_q) begin
				wr_en   = 1'b1;
				emit_go = 1'b1;
			end
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (take && emit_go) begin
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				state_d = ST_LOAD;
			end
			ST_LOAD: begin
				if (load) begin
					state_d = (k_q == last_q) ? ST_IDLE : ST_READ;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		rx_in.ready = 1'b0;
		rd_en       = 1'b0;
		load        = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				rx_in.ready = 1'b1;
			end
			ST_READ: begin
				rd_en = 1'b1;
			end
			ST_LOAD: begin
				load = ~ovld_q | fr_out.ready;
			end
			default: begin
				rx_in.ready = 1'b0;
			end
		endcase
	end

	assign take = rx_in.valid & rx_in.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q           <= ST_IDLE;
			accept_headless_q <= 1'b1;
			in_frame_q        <= 1'b0;
			hl_allowed_q      <= 1'b1;
			cnt_q             <= '0;
			xor_q             <= '0;
			len_q             <= '0;
			k_q               <= '0;
			last_q            <= '0;
			ovld_q            <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				accept_headless_q <= cfg_wdata;
			end
			if (take) begin
				in_frame_q   <= in_frame_d;
				hl_allowed_q <= hl_allowed_d;
				cnt_q        <= cnt_d;
				xor_q        <= xor_d;
				len_q        <= len_d;
				if (emit_go) begin
					k_q    <= '0;
					last_q <= cnt_q;
				end
			end
			if (load) begin
				k_q    <= k_q + AW'(1);
				ovld_q <= 1'b1;
			end else if (fr_out.ready) begin
				ovld_q <= 1'b0;
			end
		end
	end

	// output word register
	always_ff @(posedge clk) begin
		if (load) begin
			obyte_q <= (k_q == '0) ? START_BYTE : rd_data;
			oidx_q  <= IDX_W'(k_q);
			olast_q <= (k_q == last_q);
		end
	end

	assign fr_out.valid      = ovld_q;
	assign fr_out.frame_byte = obyte_q;
	assign fr_out.byte_index = oidx_q;
	assign fr_out.last_byte  = olast_q;

endmodule

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the STX length/XOR frame receiver. Byte streams go
// in one word per handshake; an internal frame tracker works out which frame
// words must come back, and each output word is compared against it in order.
// Directed cases are followed by headless on/off phases, an output hold-off,
// and random frame traffic with random gaps on both sides, then a gapless stream.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

	import stx_rx_pkg::*;

	localparam int FRAME_BYTES = 64;
	localparam int SETTLE_CYCLES = 8;
	localparam int DRAIN_CYCLES = 40;
	localparam int STALL_LIMIT = 3000;

	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic [IDX_W-1:0]  idx;
		logic              last;
	} frame_word_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic cfg_wdata;

	stx_rx_if    rx_ch ();
	stx_frame_if fr_ch ();

	stx_length_xor_frame_receiver #(
		.FRAME_BYTES(FRAME_BYTES)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.rx_in(rx_ch),
		.fr_out(fr_ch),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	// frame tracker state
	logic [BYTE_W-1:0] frame_mem [FRAME_BYTES];
	int unsigned       held;
	bit                in_frame;
	bit                headless_ok;
	logic [BYTE_W-1:0] xor_acc;
	int unsigned       pay_len;
	bit                cfg_headless;

	frame_word_t frame_words_due [$];
	int          mismatches;
	int unsigned frame_words;
	bit          src_gaps;
	bit          sink_stalls;
	int          hold_cycles;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void clear_frame();
		in_frame = 1'b0;
		held = 0;
		xor_acc = '0;
		pay_len = 0;
	endfunction

	function automatic void keep_byte(input logic [BYTE_W-1:0] b);
		if (held < FRAME_BYTES)
			frame_mem[held] = b;
		xor_acc ^= b;
		held++;
	endfunction

	function automatic void predict_rx(input logic [BYTE_W-1:0] b, input logic burst);
		int unsigned n;
		if (burst) begin
			headless_ok = 1'b1;
			clear_frame();
		end
		if (!in_frame) begin
			if (b == START_BYTE) begin
				clear_frame();
				in_frame = 1'b1;
				headless_ok = 1'b0;
				keep_byte(b);
			end else if (b != ZERO_BYTE && headless_ok && cfg_headless) begin
				clear_frame();
				in_frame = 1'b1;
				headless_ok = 1'b0;
				keep_byte(START_BYTE);
				keep_byte(b);
			end
			return;
		end
		if (held < HEADER_BYTES) begin
			keep_byte(b);
			if (held == HEADER_BYTES) begin
				pay_len = {frame_mem[LEN_HI_POS], frame_mem[LEN_LO_POS]};
				if (HEADER_BYTES + pay_len + 1 > FRAME_BYTES)
					clear_frame();
			end
			return;
		end
		if (held < HEADER_BYTES + pay_len) begin
			keep_byte(b);
			return;
		end
		// checksum word
		if (b != xor_acc || held >= FRAME_BYTES) begin
			clear_frame();
			return;
		end
		frame_mem[held] = b;
		n = held + 1;
		for (int k = 0; k < n; k++)
			frame_words_due.push_back('{data: frame_mem[k], idx: IDX_W'(k), last: (k + 1 == n)});
		clear_frame();
	endfunction

	task automatic log_mismatch(input string what, input frame_word_t want, input frame_word_t got);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch (%s): expected byte %02h index %0d last %0b, got byte %02h index %0d last %0b",
				what, want.data, want.idx, want.last, got.data, got.idx, got.last);
	endtask

	task automatic send_word(input logic [BYTE_W-1:0] b, input logic burst);
		if (src_gaps && $urandom_range(0, 5) == 0) begin
			rx_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		rx_ch.valid <= 1'b1;
		rx_ch.rx_byte <= b;
		rx_ch.burst_start <= burst;
		@(posedge clk);
		while (!rx_ch.ready) @(posedge clk);
		predict_rx(b, burst);
	endtask

	task automatic send_frame(input bit headless, input logic [BYTE_W-1:0] cmd,
			input int unsigned len, input bit bad_sum, input bit new_burst,
			input int unsigned cut_at);
		logic [BYTE_W-1:0] fb [$];
		logic [BYTE_W-1:0] sum;
		sum = START_BYTE;
		if (!headless)
			fb.push_back(START_BYTE);
		fb.push_back(cmd);
		fb.push_back(len[7:0]);
		fb.push_back(len[15:8]);
		sum ^= cmd ^ len[7:0] ^ len[15:8];
		if (HEADER_BYTES + len + 1 <= FRAME_BYTES) begin
			repeat (len) begin
				fb.push_back(BYTE_W'($urandom_range(0, 255)));
				sum ^= fb[$];
			end
			fb.push_back(bad_sum ? sum ^ BYTE_W'($urandom_range(1, 255)) : sum);
		end
		if (cut_at != 0 && cut_at < fb.size())
			fb = fb[0:cut_at-1];
		foreach (fb[i])
			send_word(fb[i], new_burst && i == 0);
		frame_words += fb.size();
	endtask

	task automatic random_frame();
		int unsigned len;
		int          pick;
		bit          hl;
		bit          nb;
		if ($urandom_range(0, 4) == 0) begin
			repeat ($urandom_range(1, 3))
				send_word($urandom_range(0, 1) ? ZERO_BYTE : BYTE_W'($urandom),
					$urandom_range(0, 3) == 0);
		end
		pick = $urandom_range(0, 99);
		if (pick < 60)
			len = $urandom_range(0, 8);
		else if (pick < 85)
			len = $urandom_range(9, 40);
		else if (pick < 90)
			len = $urandom_range(41, 58);
		else if (pick < 95)
			len = FRAME_BYTES - HEADER_BYTES - 1;
		else
			len = $urandom_range(FRAME_BYTES - HEADER_BYTES, 65535);
		hl = $urandom_range(0, 4) == 0;
		nb = hl || $urandom_range(0, 3) == 0;
		send_frame(hl, BYTE_W'($urandom), len, $urandom_range(0, 9) == 0, nb,
			$urandom_range(0, 19) == 0 ? $urandom_range(1, 5) : 0);
	endtask

	task automatic write_cfg(input logic value);
		rx_ch.valid <= 1'b0;
		while (frame_words_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		cfg_headless = value;
	endtask

	task automatic test_directed_cases();
		// zero skipped at burst start, shortest frame with 0xff command
		send_word(ZERO_BYTE, 1'b1);
		send_frame(1'b0, 8'hFF, 0, 1'b0, 1'b0, 0);
		// lost start byte, command taken from the first burst word
		send_frame(1'b1, 8'h81, 0, 1'b0, 1'b1, 0);
		// bad checksum dropped
		send_frame(1'b0, 8'h10, 0, 1'b1, 1'b0, 0);
		// length one past what the store holds
		send_frame(1'b0, 8'h01, FRAME_BYTES - HEADER_BYTES, 1'b0, 1'b0, 0);
		// stray nonzero word while hunting
		send_word(8'h55, 1'b0);
		// partial frame cut by a new burst
		send_frame(1'b0, 8'h20, 3, 1'b0, 1'b0, 2);
		send_frame(1'b0, 8'h7E, 0, 1'b0, 1'b1, 0);
	endtask

	task automatic test_headless_config();
		write_cfg(1'b0);
		send_frame(1'b1, 8'h81, 2, 1'b0, 1'b1, 0);
		send_frame(1'b0, 8'h42, 3, 1'b0, 1'b1, 0);
		repeat (3) random_frame();
		write_cfg(1'b1);
		send_frame(1'b1, 8'hC3, 2, 1'b0, 1'b1, 0);
		repeat (3) random_frame();
	endtask

	task automatic test_output_backpressure();
		src_gaps = 1'b0;
		hold_cycles = 400;
		repeat (4) send_frame(1'b0, BYTE_W'($urandom), 12, 1'b0, 1'b0, 0);
		src_gaps = 1'b1;
	endtask

	task automatic test_random_traffic();
		while (frame_words < 240) random_frame();
		write_cfg(1'b0);
		while (frame_words < 290) random_frame();
		write_cfg(1'b1);
		while (frame_words < 340) random_frame();
	endtask

	task automatic test_steady_stream();
		src_gaps = 1'b0;
		sink_stalls = 1'b0;
		repeat (6) random_frame();
	endtask

	// output ready with random stalls and the long hold-off
	initial begin : sink_ready
		int gap;
		gap = 0;
		fr_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_cycles > 0) begin
				fr_ch.ready <= 1'b0;
				hold_cycles--;
			end else if (gap > 0) begin
				fr_ch.ready <= 1'b0;
				gap--;
			end else if (sink_stalls && $urandom_range(0, 5) == 0) begin
				fr_ch.ready <= 1'b0;
				gap = $urandom_range(1, 14) - 1;
			end else begin
				fr_ch.ready <= 1'b1;
			end
		end
	end

	initial begin : frame_checker
		frame_word_t want;
		frame_word_t got;
		forever begin
			@(posedge clk);
			if (arst_n && fr_ch.valid && fr_ch.ready) begin
				got = '{data: fr_ch.frame_byte, idx: fr_ch.byte_index, last: fr_ch.last_byte};
				if (frame_words_due.size() == 0) begin
					log_mismatch("no word expected", '0, got);
				end else begin
					want = frame_words_due.pop_front();
					if (got.data !== want.data || got.idx !== want.idx || got.last !== want.last)
						log_mismatch("frame word", want, got);
				end
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (rx_ch.valid && rx_ch.ready) || (fr_ch.valid && fr_ch.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		mismatches = 0;
		frame_words = 0;
		src_gaps = 1'b1;
		sink_stalls = 1'b1;
		hold_cycles = 0;
		foreach (frame_mem[i])
			frame_mem[i] = '0;
		clear_frame();
		headless_ok = 1'b1;
		cfg_headless = 1'b1;
		arst_n <= 1'b0;
		rx_ch.valid <= 1'b0;
		rx_ch.rx_byte <= '0;
		rx_ch.burst_start <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_cases();
		test_headless_config();
		test_output_backpressure();
		test_random_traffic();
		test_steady_stream();
		rx_ch.valid <= 1'b0;
		while (frame_words_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
